/* rtl/core/frustum_cull_box_sphere_assert.svh */
// ----------------------------------------------------------------------------
// Frustum cull assertion macros
// Shared macros for the concurrent assertions of the frustum cull block.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_BOX_SPHERE_ASSERT_SVH
`define FRUSTUM_CULL_BOX_SPHERE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FCBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frustum cull check failed");

// Next-cycle implication, disabled while reset is high.
`define FCBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frustum cull check failed");

// Next-cycle implication that is also checked across reset.
`define FCBS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("frustum cull check failed");

`endif

/* rtl/core/fcbs_pkg.sv */
// ----------------------------------------------------------------------------
// Frustum cull package
// Widths, item kinds and verdict codes shared by the frustum cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package fcbs_pkg;

   localparam int FIELD_BITS = 32;
   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_BITS   = 64;
   localparam int NUM_PLANES = 6;
   localparam int PLANE_BITS = 3;
   localparam int KIND_BITS  = 2;
   localparam int VERDICT_BITS = 2;

   localparam logic [PLANE_BITS-1:0] FIRST_PLANE = '0;
   localparam logic [PLANE_BITS-1:0] LAST_PLANE  = PLANE_BITS'(NUM_PLANES - 1);

   localparam logic [KIND_BITS-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_BOX    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_SPHERE = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd3;

   localparam logic [VERDICT_BITS-1:0] VERDICT_INSIDE    = 2'd0;
   localparam logic [VERDICT_BITS-1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [VERDICT_BITS-1:0] VERDICT_OUTSIDE   = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;

   // Control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic first;   // load the scaled offset instead of accumulating
      logic enable;  // advance the product and accumulator registers
   } mac_ctrl_type;

endpackage

`default_nettype wire

/* rtl/core/fcbs_req_if.sv */
// ----------------------------------------------------------------------------
// Frustum cull request channel
// Valid/ready channel carrying one load or test word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcbs_req_if
   import fcbs_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  kind;
   logic [PLANE_BITS-1:0] plane_index;
   logic [FIELD_BITS-1:0] vec_a_x;
   logic [FIELD_BITS-1:0] vec_a_y;
   logic [FIELD_BITS-1:0] vec_a_z;
   logic [FIELD_BITS-1:0] vec_b_x;
   logic [FIELD_BITS-1:0] vec_b_y;
   logic [FIELD_BITS-1:0] vec_b_z;

   modport source (
      output valid, kind, plane_index, vec_a_x, vec_a_y, vec_a_z,
             vec_b_x, vec_b_y, vec_b_z,
      input  ready
   );

   modport sink (
      input  valid, kind, plane_index, vec_a_x, vec_a_y, vec_a_z,
             vec_b_x, vec_b_y, vec_b_z,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/fcbs_rsp_if.sv */
// ----------------------------------------------------------------------------
// Frustum cull response channel
// Valid/ready channel carrying one verdict word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcbs_rsp_if
   import fcbs_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic [VERDICT_BITS-1:0] verdict;
   logic [PLANE_BITS-1:0]   cull_plane;

   modport source (output valid, verdict, cull_plane, input ready);
   modport sink   (input valid, verdict, cull_plane, output ready);
endinterface

`default_nettype wire

/* rtl/core/fcbs_mac.sv */
// ----------------------------------------------------------------------------
// Frustum cull multiply-accumulate unit
// One signed multiplier with a registered product and a 64-bit accumulator,
// shared by every term of every plane distance.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbs_mac
   import fcbs_pkg::*;
(
   input  wire logic         clock,
   input  wire mac_ctrl_type ctrl,
   input  wire coord_type    coef,
   input  wire coord_type    point,
   input  wire coord_type    offset,
   output acc_type           dist_sum
);

   logic signed [2*COORD_BITS-1:0] mul_full;
   acc_type prod_ff, prod_in;
   acc_type acc_ff, acc_in;
   acc_type offset_scaled;

   assign mul_full      = coef * point;
   assign prod_in       = ACC_BITS'(mul_full);
   assign offset_scaled = ACC_BITS'(offset) <<< FRAC_BITS;
   assign acc_in        = ctrl.first ? offset_scaled : acc_ff + prod_ff;

   // The full distance is ready once the last product has been registered.
   assign dist_sum = acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (ctrl.enable) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/frustum_cull_box_sphere.sv */
// ----------------------------------------------------------------------------
// Frustum cull of boxes and spheres
// Six stored frustum planes; box and sphere tests with plane coherency.
// ----------------------------------------------------------------------------
// Usage: req_ch carries one word per item. A load word (kind 0) writes one
// plane; req_ch.ready stays high for back-to-back loads. A box (kind 1) or
// sphere (kind 2) word starts a test at the hinted plane and visits planes
// in circular order until one culls. Each plane distance goes through one
// shared multiplier: three products and a final add. A sphere needs one
// distance per plane, a box two (positive then negative vertex). The verdict
// then moves into the rsp_ch output register, after which the block is ready
// again. A kind 3 word is dropped without a response.
// The output register holds a verdict while rsp_ch.ready is low; new loads
// are taken while idle, but a finished test waits until the register frees.
// Reset (synchronous, active high) returns the sequencer to idle and drops a
// pending response. Plane contents are not cleared; a test must only use
// planes that have been loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_cull_box_sphere
   import fcbs_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   fcbs_req_if.sink    req_ch,
   fcbs_rsp_if.source  rsp_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   // Plane store, no reset.
   coord_type plane_nx_ff  [NUM_PLANES];
   coord_type plane_ny_ff  [NUM_PLANES];
   coord_type plane_nz_ff  [NUM_PLANES];
   coord_type plane_off_ff [NUM_PLANES];

   logic [1:0]              state_ff, state_in;
   logic                    box_ff, box_in;
   logic [PLANE_BITS-1:0]   plane_ff, plane_in;
   logic [PLANE_BITS-1:0]   count_ff, count_in;
   logic [2:0]              step_ff, step_in;
   logic [VERDICT_BITS-1:0] verdict_ff, verdict_in;
   logic [PLANE_BITS-1:0]   cull_ff, cull_in;
   coord_type               ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   acc_type                 rad_ff, nrad_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_BITS-1:0] rsp_verdict_ff;
   logic [PLANE_BITS-1:0]   rsp_cull_ff;

   logic                    accept, is_test, load_out;
   logic [1:0]              term;
   logic                    neg_phase;
   coord_type               n_sel, a_sel, b_sel, point_sel;
   coord_type               in_bx;
   acc_type                 dist_sum;
   logic                    dist_neg, sph_out, sph_touch;
   mac_ctrl_type            mac_ctrl;

   assign accept  = req_ch.valid && req_ch.ready;
   assign is_test = (req_ch.kind == KIND_BOX) || (req_ch.kind == KIND_SPHERE);
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Output register frees when empty or when the receiver takes the word.
   assign load_out = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_ch.ready);

   assign in_bx = coord_type'(req_ch.vec_b_x[COORD_BITS-1:0]);

   // Operand selection for the shared multiplier.
   assign term      = step_ff[1:0];
   assign neg_phase = step_ff[2];

   always_comb begin
      case (term)
         2'd0:    begin n_sel = plane_nx_ff[plane_ff]; a_sel = ax_ff; b_sel = bx_ff; end
         2'd1:    begin n_sel = plane_ny_ff[plane_ff]; a_sel = ay_ff; b_sel = by_ff; end
         default: begin n_sel = plane_nz_ff[plane_ff]; a_sel = az_ff; b_sel = bz_ff; end
      endcase
   end

   // Positive vertex takes the maximum where the normal is non-negative;
   // the negative vertex takes the opposite corner.
   assign point_sel = (box_ff && (!n_sel[COORD_BITS-1] ^ neg_phase)) ? b_sel : a_sel;

   assign mac_ctrl.first  = (term == 2'd0);
   assign mac_ctrl.enable = (state_ff == ST_RUN);

   fcbs_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .coef     (n_sel),
      .point    (point_sel),
      .offset   (plane_off_ff[plane_ff]),
      .dist_sum (dist_sum)
   );

   assign dist_neg  = dist_sum[ACC_BITS-1];
   assign sph_out   = dist_sum < nrad_ff;
   assign sph_touch = dist_sum < rad_ff;

   always_comb begin
      state_in   = state_ff;
      box_in     = box_ff;
      plane_in   = plane_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      verdict_in = verdict_ff;
      cull_in    = cull_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_test) begin
               state_in   = ST_RUN;
               box_in     = (req_ch.kind == KIND_BOX);
               plane_in   = (req_ch.plane_index > LAST_PLANE) ? FIRST_PLANE
                                                              : req_ch.plane_index;
               cull_in    = plane_in;
               count_in   = '0;
               step_in    = '0;
               verdict_in = VERDICT_INSIDE;
            end
         end
         ST_RUN: begin
            if (term != 2'd3) begin
               step_in = step_ff + 3'd1;
            end else begin
               priority if ((box_ff && !neg_phase && dist_neg) || (!box_ff && sph_out)) begin
                  verdict_in = VERDICT_OUTSIDE;
                  cull_in    = plane_ff;
                  state_in   = ST_SEND;
               end else if (box_ff && !neg_phase) begin
                  step_in = 3'd4;
               end else begin
                  if ((box_ff && dist_neg) || (!box_ff && sph_touch)) begin
                     verdict_in = VERDICT_INTERSECT;
                  end
                  if (count_ff == LAST_PLANE) begin
                     state_in = ST_SEND;
                  end else begin
                     count_in = count_ff + 1'b1;
                     plane_in = (plane_ff == LAST_PLANE) ? FIRST_PLANE : plane_ff + 1'b1;
                     step_in  = '0;
                  end
               end
            end
         end
         ST_SEND: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      box_ff     <= box_in;
      plane_ff   <= plane_in;
      count_ff   <= count_in;
      step_ff    <= step_in;
      verdict_ff <= verdict_in;
      cull_ff    <= cull_in;
      if (accept && is_test) begin
         ax_ff   <= coord_type'(req_ch.vec_a_x[COORD_BITS-1:0]);
         ay_ff   <= coord_type'(req_ch.vec_a_y[COORD_BITS-1:0]);
         az_ff   <= coord_type'(req_ch.vec_a_z[COORD_BITS-1:0]);
         bx_ff   <= in_bx;
         by_ff   <= coord_type'(req_ch.vec_b_y[COORD_BITS-1:0]);
         bz_ff   <= coord_type'(req_ch.vec_b_z[COORD_BITS-1:0]);
         rad_ff  <= ACC_BITS'(in_bx) <<< FRAC_BITS;
         nrad_ff <= acc_type'(-(ACC_BITS'(in_bx) <<< FRAC_BITS));
      end
      if (load_out) begin
         rsp_verdict_ff <= verdict_ff;
         rsp_cull_ff    <= cull_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_ch.kind == KIND_LOAD) && (req_ch.plane_index <= LAST_PLANE)) begin
         plane_nx_ff[req_ch.plane_index]  <= coord_type'(req_ch.vec_a_x[COORD_BITS-1:0]);
         plane_ny_ff[req_ch.plane_index]  <= coord_type'(req_ch.vec_a_y[COORD_BITS-1:0]);
         plane_nz_ff[req_ch.plane_index]  <= coord_type'(req_ch.vec_a_z[COORD_BITS-1:0]);
         plane_off_ff[req_ch.plane_index] <= in_bx;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.verdict    = rsp_verdict_ff;
   assign rsp_ch.cull_plane = rsp_cull_ff;

endmodule

`default_nettype wire

/* rtl/core/fcbs_checker.sv */
// ----------------------------------------------------------------------------
// Frustum cull port checker
// Watches the request and response ports of the frustum cull block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frustum_cull_box_sphere_assert.svh"

module fcbs_checker
   import fcbs_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic [KIND_BITS-1:0]    req_kind,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [VERDICT_BITS-1:0] rsp_verdict
);

   logic req_take, test_take, quiet_take;

   assign req_take   = req_valid && req_ready;
   assign test_take  = req_take && ((req_kind == KIND_BOX) || (req_kind == KIND_SPHERE));
   assign quiet_take = req_take && ((req_kind == KIND_LOAD) || (req_kind == KIND_NONE));

   `FCBS_ASSERT_NEXT_ALWAYS(a_reset_drops_rsp, clock, reset, !rsp_valid)
   `FCBS_ASSERT_NEXT(a_test_goes_busy, clock, reset, test_take, !req_ready)
   `FCBS_ASSERT_NEXT(a_load_stays_ready, clock, reset, quiet_take, req_ready)
   `FCBS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `FCBS_ASSERT_NOW(a_verdict_code, clock, reset, rsp_valid,
      (rsp_verdict == VERDICT_INSIDE) || (rsp_verdict == VERDICT_INTERSECT) ||
      (rsp_verdict == VERDICT_OUTSIDE))

endmodule

bind frustum_cull_box_sphere fcbs_checker u_fcbs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_kind    (req_ch.kind),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_verdict (rsp_ch.verdict)
);

`default_nettype wire
